// ===== hw/rtl/pab_pkg.sv =====
// Shared types and constants for the pixel alpha blend store.
package pab_pkg;

   // Register port geometry
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 9;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CANVAS_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CANVAS_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_RED      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_GREEN    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_BLUE     = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_ALPHA    = 3'd5;

   // Reset value of every register: 256 columns/rows, unity gain in Q1.8
   localparam logic [CSR_DATA_BITS-1:0] CSR_RESET_VALUE = 9'd256;

   // Item actions
   localparam logic ACTION_BLEND = 1'b0;
   localparam logic ACTION_READ  = 1'b1;

   // Byte conversion factor on read
   localparam logic [7:0] READ_SCALE = 8'd255;

   // Channel count per pixel and Q1.8 source width
   localparam int NUM_CHANNELS = 4;
   localparam int SRC_BITS     = 9;

   typedef struct packed {
      logic                action;
      logic signed [15:0]  pos_x;
      logic signed [15:0]  pos_y;
      logic [SRC_BITS-1:0] src_red;
      logic [SRC_BITS-1:0] src_green;
      logic [SRC_BITS-1:0] src_blue;
      logic [SRC_BITS-1:0] src_alpha;
   } pab_req_type;

   typedef struct packed {
      logic       accepted;
      logic [7:0] read_red;
      logic [7:0] read_green;
      logic [7:0] read_blue;
      logic [7:0] read_alpha;
   } pab_rsp_type;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] canvas_width;
      logic [CSR_DATA_BITS-1:0] canvas_height;
      logic [CSR_DATA_BITS-1:0] gain_red;
      logic [CSR_DATA_BITS-1:0] gain_green;
      logic [CSR_DATA_BITS-1:0] gain_blue;
      logic [CSR_DATA_BITS-1:0] gain_alpha;
   } pab_cfg_type;

   // Stage loads for the blend datapath
   typedef struct packed {
      logic load_scale;
      logic load_prod;
   } pab_dp_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_BLEND,
      ST_WRITE
   } pab_state_type;

endpackage

// ===== hw/rtl/pab_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module pab_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 65536
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH < 2 ? 1 : $clog2(DEPTH))-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH < 2 ? 1 : $clog2(DEPTH))-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// ===== hw/rtl/pab_csr.sv =====
// Configuration registers: canvas size and per-channel gains.
module pab_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [pab_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pab_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output pab_pkg::pab_cfg_type                 cfg
);
   import pab_pkg::*;

   pab_cfg_type cfg_ff;

   // Write the addressed register; drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.canvas_width  <= CSR_RESET_VALUE;
         cfg_ff.canvas_height <= CSR_RESET_VALUE;
         cfg_ff.gain_red      <= CSR_RESET_VALUE;
         cfg_ff.gain_green    <= CSR_RESET_VALUE;
         cfg_ff.gain_blue     <= CSR_RESET_VALUE;
         cfg_ff.gain_alpha    <= CSR_RESET_VALUE;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CANVAS_WIDTH:  cfg_ff.canvas_width  <= csr_wdata;
            CSR_CANVAS_HEIGHT: cfg_ff.canvas_height <= csr_wdata;
            CSR_GAIN_RED:      cfg_ff.gain_red      <= csr_wdata;
            CSR_GAIN_GREEN:    cfg_ff.gain_green    <= csr_wdata;
            CSR_GAIN_BLUE:     cfg_ff.gain_blue     <= csr_wdata;
            CSR_GAIN_ALPHA:    cfg_ff.gain_alpha    <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/pab_blend.sv =====
// Blend datapath: gain scaling, source-over products and byte conversion.
module pab_blend #(
   parameter int CHANNEL_BITS = 9
) (
   input  logic                                           clock,
   input  pab_pkg::pab_dp_ctl_type                        ctl,
   input  pab_pkg::pab_req_type                           item,
   input  pab_pkg::pab_cfg_type                           cfg,
   input  logic [pab_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] dst_pixel,
   output logic [pab_pkg::NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] new_pixel,
   output logic [pab_pkg::NUM_CHANNELS-1:0][7:0]              read_bytes
);
   import pab_pkg::*;

   localparam int FRAC  = CHANNEL_BITS - 1;
   localparam int SHIFT = 16 - FRAC;
   localparam int SPW   = 2 * SRC_BITS;
   localparam int PW    = 2 * CHANNEL_BITS;
   localparam int RW    = CHANNEL_BITS + 8;
   localparam logic [CHANNEL_BITS-1:0] ONE = {1'b1, {FRAC{1'b0}}};

   logic [SRC_BITS-1:0]     src      [NUM_CHANNELS];
   logic [SRC_BITS-1:0]     gain     [NUM_CHANNELS];
   logic [SPW-1:0]          scale_prod [NUM_CHANNELS];
   logic [SPW-1:0]          scale_shr  [NUM_CHANNELS];
   logic [CHANNEL_BITS-1:0] scale_in [NUM_CHANNELS];
   logic [CHANNEL_BITS-1:0] scale_ff [NUM_CHANNELS];
   logic [CHANNEL_BITS-1:0] inv_alpha;
   logic [PW-1:0]           keep_in  [NUM_CHANNELS];
   logic [PW-1:0]           keep_ff  [NUM_CHANNELS];
   logic [PW-1:0]           add_in   [NUM_CHANNELS];
   logic [PW-1:0]           add_ff   [NUM_CHANNELS];
   logic [RW-1:0]           rd_in    [NUM_CHANNELS];
   logic [RW-1:0]           rd_ff    [NUM_CHANNELS];
   logic [PW-1:0]           blend_sum [NUM_CHANNELS];

   // Channel order: red, green, blue, alpha
   assign src[0]  = item.src_red;
   assign src[1]  = item.src_green;
   assign src[2]  = item.src_blue;
   assign src[3]  = item.src_alpha;
   assign gain[0] = cfg.gain_red;
   assign gain[1] = cfg.gain_green;
   assign gain[2] = cfg.gain_blue;
   assign gain[3] = cfg.gain_alpha;

   // Scale each source channel by its gain and saturate at one
   always_comb begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         scale_prod[k] = SPW'(src[k]) * SPW'(gain[k]);
         scale_shr[k]  = scale_prod[k] >> SHIFT;
         scale_in[k]   = (scale_shr[k] > SPW'(ONE)) ? ONE : CHANNEL_BITS'(scale_shr[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_scale) begin
         scale_ff <= scale_in;
      end
   end

   // Form keep and add products; the alpha lane multiplies alpha by itself
   assign inv_alpha = ONE - scale_ff[NUM_CHANNELS-1];

   always_comb begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         keep_in[k] = PW'(dst_pixel[k]) * PW'(inv_alpha);
         add_in[k]  = PW'(scale_ff[k]) * PW'(scale_ff[NUM_CHANNELS-1]);
         rd_in[k]   = RW'(dst_pixel[k]) * RW'(READ_SCALE);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_prod) begin
         keep_ff <= keep_in;
         add_ff  <= add_in;
         rd_ff   <= rd_in;
      end
   end

   // Truncate and sum into the new pixel; convert stored value to a byte
   always_comb begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         blend_sum[k]  = (keep_ff[k] >> FRAC) + (add_ff[k] >> FRAC);
         new_pixel[k]  = CHANNEL_BITS'(blend_sum[k]);
         read_bytes[k] = 8'(rd_ff[k] >> FRAC);
      end
   end

endmodule

// ===== hw/rtl/pixel_alpha_blend_store_core.sv =====
// Top level of the pixel alpha blend store: sequencer, pixel memory and result register.
//
// Frame-buffer blend engine. Each request beat either blends a Q1.8 RGBA color into the
// pixel at (pos_x, pos_y) (source-over, per-channel gain applied first) or reads that
// pixel back as four bytes; every request yields exactly one response beat, with
// accepted low for positions outside the configured canvas. One item is in flight at a
// time: the read-modify-write through the single pixel memory runs from acceptance to the
// response register through accept, memory read and gain scaling, blend products and
// write-back, so the block takes no new request until the current item is written back.
// A waiting response does not block the next request. After reset the block sweeps all
// MAX_WIDTH*MAX_HEIGHT pixels of the memory to zero, one pixel per cycle, holding
// req_stall high; register writes are taken throughout.
module pixel_alpha_blend_store_core #(
   parameter int MAX_WIDTH    = 256,
   parameter int MAX_HEIGHT   = 256,
   parameter int CHANNEL_BITS = 9
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  pab_pkg::pab_req_type               req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output pab_pkg::pab_rsp_type               rsp_data,
   input  logic                               csr_wr_en,
   input  logic [pab_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [pab_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import pab_pkg::*;

   localparam int NPIX  = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (NPIX < 2) ? 1 : $clog2(NPIX);
   localparam int PIX_W = NUM_CHANNELS * CHANNEL_BITS;
   localparam logic [AW-1:0] LAST_ADDR = AW'(NPIX - 1);

   pab_state_type  state_ff, state_in;
   logic [AW-1:0]  clr_ff, clr_in;
   pab_req_type    item_ff;
   logic           item_load;
   logic           hit_ff;
   logic [AW-1:0]  addr_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   pab_rsp_type    rsp_ff;
   logic           rsp_load;
   pab_dp_ctl_type dp_ctl;
   pab_cfg_type    cfg;

   logic           mem_we;
   logic [AW-1:0]  mem_waddr;
   logic [PIX_W-1:0] mem_wdata;
   logic           mem_re;
   logic [PIX_W-1:0] mem_rdata;

   logic [15:0]    w_lim;
   logic [15:0]    h_lim;
   logic           hit;
   logic [31:0]    lin_addr;

   logic [NUM_CHANNELS-1:0][CHANNEL_BITS-1:0] new_pixel;
   logic [NUM_CHANNELS-1:0][7:0]              read_bytes;

   pab_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pab_ram #(
      .WIDTH (PIX_W),
      .DEPTH (NPIX)
   ) u_pixel_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (lin_addr[AW-1:0]),
      .rdata (mem_rdata)
   );

   pab_blend #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_blend (
      .clock      (clock),
      .ctl        (dp_ctl),
      .item       (item_ff),
      .cfg        (cfg),
      .dst_pixel  (mem_rdata),
      .new_pixel  (new_pixel),
      .read_bytes (read_bytes)
   );

   // Clip the canvas to the memory size and check the position
   always_comb begin
      w_lim = (16'(cfg.canvas_width) > 16'(MAX_WIDTH)) ? 16'(MAX_WIDTH)
                                                        : 16'(cfg.canvas_width);
      h_lim = (16'(cfg.canvas_height) > 16'(MAX_HEIGHT)) ? 16'(MAX_HEIGHT)
                                                          : 16'(cfg.canvas_height);
      hit = !item_ff.pos_x[15] && !item_ff.pos_y[15] &&
            (item_ff.pos_x[15:0] < w_lim) && (item_ff.pos_y[15:0] < h_lim);
      lin_addr = 32'(item_ff.pos_y[15:0]) * 32'(MAX_WIDTH) + 32'(item_ff.pos_x[15:0]);
   end

   // Sequence clearing and the read-modify-write of one item
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_stall    = 1'b1;
      item_load    = 1'b0;
      dp_ctl       = '0;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = addr_ff;
      mem_wdata    = new_pixel;
      rsp_load     = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               item_load = 1'b1;
               state_in  = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            dp_ctl.load_scale = 1'b1;
            mem_re            = 1'b1;
            state_in          = ST_BLEND;
         end
         ST_BLEND: begin
            dp_ctl.load_prod = 1'b1;
            state_in         = ST_WRITE;
         end
         ST_WRITE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               mem_we   = hit_ff && (item_ff.action == ACTION_BLEND);
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   // Hold the item and its decoded position
   always_ff @(posedge clock) begin
      if (item_load) begin
         item_ff <= req_data;
      end
      if (dp_ctl.load_scale) begin
         hit_ff  <= hit;
         addr_ff <= lin_addr[AW-1:0];
      end
   end

   // Load the response register; clear valid once the beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff.accepted <= hit_ff;
         if (hit_ff && (item_ff.action == ACTION_READ)) begin
            rsp_ff.read_red   <= read_bytes[0];
            rsp_ff.read_green <= read_bytes[1];
            rsp_ff.read_blue  <= read_bytes[2];
            rsp_ff.read_alpha <= read_bytes[3];
         end else begin
            rsp_ff.read_red   <= '0;
            rsp_ff.read_green <= '0;
            rsp_ff.read_blue  <= '0;
            rsp_ff.read_alpha <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hw/rtl/pab_checker.sv =====
// Port-level checks for the pixel alpha blend store, bound to the top level.
module pab_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input pab_pkg::pab_req_type               req_data,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input pab_pkg::pab_rsp_type               rsp_data,
   input logic                               csr_wr_en,
   input logic [pab_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [pab_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import pab_pkg::*;

   // A stalled response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // A rejected position never carries pixel bytes
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |->
         rsp_data.read_red == 8'd0 && rsp_data.read_green == 8'd0 &&
         rsp_data.read_blue == 8'd0 && rsp_data.read_alpha == 8'd0)
      else $error("rejected response carries pixel data");

   // The memory clear holds off requests right after reset
   a_clear_stall: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("request taken during memory clear");

   // One item in flight: a taken request is followed by a stall
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second request taken while an item is in flight");

endmodule

bind pixel_alpha_blend_store_core pab_checker u_pab_checker (.*);
